// ----- rtl/core/zsbf_pkg.sv -----
package zsbf_pkg;

	// input command codes
	localparam logic CMD_START = 1'b0;
	localparam logic CMD_DATA  = 1'b1;

	// zlib header: deflate, 32K window, no dictionary, fastest level
	localparam logic [7:0] ZLIB_CMF = 8'h78;
	localparam logic [7:0] ZLIB_FLG = 8'h01;

	localparam logic [16:0] ADLER_MOD = 17'd65521;
	localparam logic [15:0] MAX_BLOCK = 16'hFFFF;

	// header and checksum sizes in bytes
	localparam logic [3:0] HDR_BYTES = 4'd5;
	localparam logic [3:0] CKS_BYTES = 4'd4;

	typedef struct packed {
		logic       cmd;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_run;
		logic       end_of_stream;
		logic       overrun;
	} out_item_t;

	// everything needed to play back the bytes caused by one input transaction
	typedef struct packed {
		logic        pre_two;   // two leading bytes (zlib header) instead of one
		logic [7:0]  pre0;
		logic [7:0]  pre1;
		logic        has_hdr;
		logic        hdr_final;
		logic [15:0] hdr_len;
		logic        has_cks;
		logic [31:0] cks;
		logic        ovr;
	} run_t;

endpackage

// ----- rtl/core/zsbf_core.sv -----
module zsbf_core import zsbf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data,
	input  logic        accept,
	input  in_item_t    item,
	output run_t        run
);

	logic [31:0] total_length_q;
	logic [15:0] adler_low_q;
	logic [15:0] adler_high_q;
	logic [31:0] bytes_taken_q;
	logic [15:0] block_rem_q;
	logic        open_q;

	logic [31:0] taken_inc;
	logic [31:0] left;
	logic [15:0] blk_len;
	logic        blk_final;
	logic [16:0] low_sum;
	logic [16:0] low_new;
	logic [16:0] high_sum;
	logic [16:0] high_new;
	logic [15:0] rem_dec;
	logic        is_start;
	logic        is_ovr;
	logic        stream_done;

	assign is_start    = (item.cmd == CMD_START);
	assign taken_inc   = bytes_taken_q + 32'd1;
	assign rem_dec     = block_rem_q - 16'd1;
	assign is_ovr      = !open_q || (bytes_taken_q >= total_length_q);
	assign stream_done = (taken_inc == total_length_q);

	// bytes still to come after this transaction
	assign left      = is_start ? total_length_q : (total_length_q - taken_inc);
	assign blk_len   = (left < {16'd0, MAX_BLOCK}) ? left[15:0] : MAX_BLOCK;
	assign blk_final = ({16'd0, blk_len} == left);

	// Adler-32: add, then one conditional subtract per sum
	assign low_sum  = {1'b0, adler_low_q} + {9'd0, item.data_byte};
	assign low_new  = (low_sum >= ADLER_MOD) ? (low_sum - ADLER_MOD) : low_sum;
	assign high_sum = {1'b0, adler_high_q} + low_new;
	assign high_new = (high_sum >= ADLER_MOD) ? (high_sum - ADLER_MOD) : high_sum;

	always_comb begin
		run           = '0;
		run.hdr_final = blk_final;
		run.hdr_len   = blk_len;
		if (is_start) begin
			run.pre_two = 1'b1;
			run.pre0    = ZLIB_CMF;
			run.pre1    = ZLIB_FLG;
			run.has_hdr = 1'b1;
			run.has_cks = (total_length_q == 32'd0);
			run.cks     = 32'h0000_0001;
		end else if (is_ovr) begin
			run.ovr     = 1'b1;
		end else begin
			run.pre0    = item.data_byte;
			run.has_cks = stream_done;
			run.cks     = {high_new[15:0], low_new[15:0]};
			run.has_hdr = !stream_done && (rem_dec == 16'd0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_length_q <= '0;
			adler_low_q    <= 16'd1;
			adler_high_q   <= '0;
			bytes_taken_q  <= '0;
			block_rem_q    <= '0;
			open_q         <= 1'b0;
		end else begin
			if (cfg_wr_en)
				total_length_q <= cfg_wr_data;
			if (accept) begin
				if (is_start) begin
					adler_low_q   <= 16'd1;
					adler_high_q  <= '0;
					bytes_taken_q <= '0;
					block_rem_q   <= blk_len;
					open_q        <= (total_length_q != 32'd0);
				end else if (!is_ovr) begin
					adler_low_q   <= low_new[15:0];
					adler_high_q  <= high_new[15:0];
					bytes_taken_q <= taken_inc;
					if (stream_done)
						open_q <= 1'b0;
					if (!stream_done && rem_dec == 16'd0)
						block_rem_q <= blk_len;
					else
						block_rem_q <= rem_dec;
				end
			end
		end
	end

endmodule

// ----- rtl/core/zsbf_serializer.sv -----
module zsbf_serializer import zsbf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      load,
	input  run_t      run,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);

	run_t       run_q;
	logic       busy_q;
	logic [3:0] idx_q;

	logic [3:0] pre_cnt;
	logic [3:0] run_len;
	logic [3:0] j;
	logic [3:0] k;
	logic       last;
	logic [15:0] inv_len;

	assign pre_cnt = run_q.pre_two ? 4'd2 : 4'd1;
	assign run_len = pre_cnt + (run_q.has_hdr ? HDR_BYTES : 4'd0)
	               + (run_q.has_cks ? CKS_BYTES : 4'd0);
	assign last    = (idx_q == run_len - 4'd1);
	assign j       = idx_q - pre_cnt;
	assign k       = run_q.has_hdr ? (j - HDR_BYTES) : j;
	assign inv_len = ~run_q.hdr_len;

	assign out_valid = busy_q;
	assign in_ready  = !busy_q || (out_ready && last);

	always_comb begin
		out_item               = '0;
		out_item.last_of_run   = last;
		out_item.end_of_stream = run_q.has_cks && last;
		out_item.overrun       = run_q.ovr;
		if (idx_q < pre_cnt) begin
			out_item.out_byte = (idx_q == 4'd0) ? run_q.pre0 : run_q.pre1;
		end else if (run_q.has_hdr && j < HDR_BYTES) begin
			case (j[2:0])
				3'd0:    out_item.out_byte = {7'd0, run_q.hdr_final};
				3'd1:    out_item.out_byte = run_q.hdr_len[7:0];
				3'd2:    out_item.out_byte = run_q.hdr_len[15:8];
				3'd3:    out_item.out_byte = inv_len[7:0];
				default: out_item.out_byte = inv_len[15:8];
			endcase
		end else begin
			case (k[1:0])
				2'd0:    out_item.out_byte = run_q.cks[31:24];
				2'd1:    out_item.out_byte = run_q.cks[23:16];
				2'd2:    out_item.out_byte = run_q.cks[15:8];
				default: out_item.out_byte = run_q.cks[7:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (busy_q && out_ready) begin
			if (last)
				busy_q <= 1'b0;
			else
				idx_q <= idx_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			run_q <= run;
	end

endmodule

// ----- rtl/core/zlib_stored_block_framer.sv -----
// channel | dir | handshake           | payload
// cfg     | in  | cfg_wr_en           | cfg_wr_data : total_length, 32 bit
// in      | in  | in_valid / in_ready | in_item     : in_item_t (cmd, data_byte)
// out     | out | out_valid/out_ready | out_item    : out_item_t (one stream byte)
//
// An input transaction is folded into the framing state and registered as a run
// descriptor on acceptance; the run plays out at one byte per cycle while out_ready
// is high. A content byte gives 1 byte, 6 at a block end or 5 at a stream end; an
// overrun item gives 1; a start gives 7, or 11 for empty content. The run length
// is set by the transaction kind. in_ready rises again on the cycle the last byte
// of the run is taken, so content bytes stream at one per cycle while out_ready is
// high. Asynchronous active-low reset restarts the sums and clears the counters,
// stream flag and output run; stalls on out_ready hold the current byte and block the input.
module zlib_stored_block_framer import zsbf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_item_t    in_item,
	output logic        out_valid,
	input  logic        out_ready,
	output out_item_t   out_item
);

	logic accept;
	run_t run;

	assign accept = in_valid && in_ready;

	// Adler sums, byte and block counters; builds the descriptor for this transaction
	zsbf_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.accept      (accept),
		.item        (in_item),
		.run         (run)
	);

	// holds the descriptor and steps through its bytes
	zsbf_serializer u_ser (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept),
		.run       (run),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule

// ----- rtl/core/zsbf_checker.sv -----
module zsbf_checker import zsbf_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_item
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("output transaction dropped or changed while stalled");

	a_in_gives_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("accepted input produced no output");

	a_run_blocks_in: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !(out_ready && out_item.last_of_run) |-> !in_ready)
		else $error("input taken while a run is still pending");

	a_eos_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.end_of_stream |-> out_item.last_of_run)
		else $error("end of stream not on last byte of run");

	a_ovr_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.overrun |->
			out_item.last_of_run && !out_item.end_of_stream && out_item.out_byte == 8'd0)
		else $error("malformed overrun transaction");

endmodule

bind zlib_stored_block_framer zsbf_checker u_zsbf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_item  (out_item)
);

// ----- bench/zlib_stored_block_framer_tb.sv -----
`timescale 1ns / 100ps

module zlib_stored_block_framer_tb;
	import zsbf_pkg::*;

	// clock, reset and block ports; every input known from time zero
	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        cfg_wr_en   = 1'b0;
	logic [31:0] cfg_wr_data = '0;
	logic        in_valid    = 1'b0;
	logic        in_ready;
	in_item_t    in_item     = '0;
	logic        out_valid;
	logic        out_ready   = 1'b0;
	out_item_t   out_item;

	// traffic shaping, percent of cycles idle on each side
	int send_idle_pct = 37;
	int recv_idle_pct = 60;

	// items waiting for the driver, stream bytes waiting for the monitor
	in_item_t  items_to_send[$];
	out_item_t zlib_bytes_due[$];

	// shadow of the framer: register copy and framing state
	logic [31:0] total_len_cfg = '0;
	logic [15:0] sum_low       = 16'd1;
	logic [15:0] sum_high      = '0;
	logic [31:0] bytes_framed  = '0;
	logic [15:0] block_left    = '0;
	logic        stream_live   = 1'b0;

	// bookkeeping
	int items_queued    = 0;
	int items_sent      = 0;
	int results_checked = 0;
	int streams_closed  = 0;
	int overruns_seen   = 0;
	int error_count     = 0;

	zlib_stored_block_framer uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_item     (in_item),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_item    (out_item)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Framing predictor
	// ------------------------------------------------------------------

	task automatic emit_byte(input logic [7:0] b, input logic eos, input logic ovr);
		out_item_t r;
		r.out_byte      = b;
		r.last_of_run   = 1'b0;
		r.end_of_stream = eos;
		r.overrun       = ovr;
		zlib_bytes_due.insert(zlib_bytes_due.size(), r);
	endtask

	// stored block header: BFINAL, LEN (LE), NLEN (LE); loads the block count
	task automatic emit_block_header();
		logic [31:0] left;
		logic [31:0] len;
		logic [15:0] nlen;
		left = total_len_cfg - bytes_framed;
		len  = (left < {16'd0, MAX_BLOCK}) ? left : {16'd0, MAX_BLOCK};
		nlen = ~len[15:0];
		block_left = len[15:0];
		emit_byte({7'd0, len == left}, 1'b0, 1'b0);
		emit_byte(len[7:0], 1'b0, 1'b0);
		emit_byte(len[15:8], 1'b0, 1'b0);
		emit_byte(nlen[7:0], 1'b0, 1'b0);
		emit_byte(nlen[15:8], 1'b0, 1'b0);
	endtask

	// Adler-32 trailer, big-endian, high sum first; closes the stream
	task automatic emit_checksum();
		emit_byte(sum_high[15:8], 1'b0, 1'b0);
		emit_byte(sum_high[7:0], 1'b0, 1'b0);
		emit_byte(sum_low[15:8], 1'b0, 1'b0);
		emit_byte(sum_low[7:0], 1'b1, 1'b0);
		stream_live = 1'b0;
	endtask

	// fold one accepted input transaction into the shadow state
	task automatic frame_transaction(input in_item_t it);
		logic [16:0] acc;
		out_item_t   tail;
		if (it.cmd == CMD_START) begin
			// also abandons a stream left open
			sum_low      = 16'd1;
			sum_high     = '0;
			bytes_framed = '0;
			stream_live  = 1'b1;
			emit_byte(ZLIB_CMF, 1'b0, 1'b0);
			emit_byte(ZLIB_FLG, 1'b0, 1'b0);
			emit_block_header();
			if (total_len_cfg == 0)
				emit_checksum();
		end else if (!stream_live || bytes_framed >= total_len_cfg) begin
			emit_byte(8'h00, 1'b0, 1'b1);
		end else begin
			emit_byte(it.data_byte, 1'b0, 1'b0);
			acc = {1'b0, sum_low} + {9'd0, it.data_byte};
			if (acc >= ADLER_MOD)
				acc = acc - ADLER_MOD;
			sum_low = acc[15:0];
			acc = {1'b0, sum_high} + {1'b0, sum_low};
			if (acc >= ADLER_MOD)
				acc = acc - ADLER_MOD;
			sum_high     = acc[15:0];
			bytes_framed = bytes_framed + 32'd1;
			block_left   = block_left - 16'd1;
			// stream end wins over a block boundary
			if (bytes_framed == total_len_cfg)
				emit_checksum();
			else if (block_left == 0)
				emit_block_header();
		end
		// flag the final byte caused by this transaction
		tail = zlib_bytes_due.pop_back();
		tail.last_of_run = 1'b1;
		zlib_bytes_due.insert(zlib_bytes_due.size(), tail);
	endtask

	// ------------------------------------------------------------------
	// Driver: one input transaction per handshake, gaps at random
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				frame_transaction(in_item);
				items_sent++;
			end
			// payload may only move once the current one has gone
			if (!in_valid || in_ready) begin
				if (items_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_item  <= items_to_send.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: check each output transaction against the oldest due byte
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		out_item_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				results_checked++;
				if (out_item.end_of_stream)
					streams_closed++;
				if (out_item.overrun)
					overruns_seen++;
				if (zlib_bytes_due.size() == 0) begin
					error_count++;
					if (error_count <= 10)
						$display("%0t: unexpected byte %h last %b eos %b ovr %b", $time,
							out_item.out_byte, out_item.last_of_run,
							out_item.end_of_stream, out_item.overrun);
				end else begin
					want = zlib_bytes_due.pop_front();
					if (out_item.out_byte !== want.out_byte ||
							out_item.last_of_run !== want.last_of_run ||
							out_item.end_of_stream !== want.end_of_stream ||
							out_item.overrun !== want.overrun) begin
						error_count++;
						if (error_count <= 10)
							$display("%0t: mismatch exp byte %h last %b eos %b ovr %b,",
								$time, want.out_byte, want.last_of_run,
								want.end_of_stream, want.overrun,
								" got byte %h last %b eos %b ovr %b",
								out_item.out_byte, out_item.last_of_run,
								out_item.end_of_stream, out_item.overrun);
					end
				end
			end
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	task automatic queue_item(input logic cmd, input logic [7:0] b);
		in_item_t it;
		it.cmd       = cmd;
		it.data_byte = b;
		items_to_send.insert(items_to_send.size(), it);
		items_queued++;
	endtask

	// skewed towards 0xFF so the Adler sums wrap often
	function automatic logic [7:0] pick_byte();
		int r;
		r = $urandom_range(99);
		if (r < 25)
			return 8'hFF;
		else if (r < 35)
			return 8'h00;
		return 8'($urandom_range(255));
	endfunction

	// all queued transactions accepted and every stream byte seen
	task automatic settle();
		do
			@(negedge clk);
		while (items_to_send.size() != 0 || in_valid || zlib_bytes_due.size() != 0);
	endtask

	// register write, only once the framer has gone quiet
	task automatic set_total(input logic [31:0] value);
		settle();
		@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		total_len_cfg = value;
	endtask

	task automatic queue_bytes(input int n);
		for (int i = 0; i < n; i++)
			queue_item(CMD_DATA, pick_byte());
	endtask

	// mostly well-formed streams, some cut short, some retargeted mid-stream,
	// with a sprinkling of loose transactions
	task automatic random_traffic(input int upto);
		logic [31:0] total;
		logic [31:0] retarget;
		int          fill;
		int          cut;
		int          shape;
		int          r;
		while (items_queued < upto) begin
			if ($urandom_range(99) < 12) begin
				queue_item(1'($urandom_range(1)), 8'($urandom_range(255)));
			end else begin
				r = $urandom_range(99);
				if (r < 8)
					total = 0;
				else if (r < 70)
					total = $urandom_range(24, 1);
				else if (r < 88)
					total = $urandom_range(60, 25);
				else if (r < 94)
					total = 32'd65534 + $urandom_range(2);
				else
					total = $urandom();
				set_total(total);
				queue_item(CMD_START, 8'($urandom_range(255)));
				fill  = (total < 40) ? int'(total) : $urandom_range(40);
				shape = $urandom_range(99);
				if (shape < 15 && fill > 0) begin
					// left unfinished, the next start abandons it
					queue_bytes($urandom_range(fill - 1));
				end else if (shape < 35 && fill > 1) begin
					// register moved while the stream is open
					cut = $urandom_range(fill - 1, 1);
					queue_bytes(cut);
					retarget = cut + $urandom_range(30);
					set_total(retarget);
					queue_bytes(int'(retarget) - cut + $urandom_range(1));
				end else begin
					queue_bytes(fill);
					if ($urandom_range(3) == 0)
						queue_bytes($urandom_range(2, 1));
				end
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// phase 1: sender idles 37 %, receiver 60 %

		// data with no stream open
		queue_item(CMD_DATA, 8'h00);

		// empty content: one empty final block and checksum 00 00 00 01
		set_total(32'd0);
		queue_item(CMD_START, 8'hFF);
		queue_item(CMD_DATA, 8'hFF);

		// short stream, then a byte beyond the total
		set_total(32'd3);
		queue_item(CMD_START, 8'h00);
		queue_item(CMD_DATA, 8'h00);
		queue_item(CMD_DATA, 8'hFF);
		queue_item(CMD_DATA, 8'h80);
		queue_item(CMD_DATA, 8'h55);

		// largest total: first block full size, not final
		set_total(32'hFFFF_FFFF);
		queue_item(CMD_START, 8'h00);
		queue_item(CMD_DATA, 8'h01);

		// restart over an open stream
		set_total(32'd2);
		queue_item(CMD_START, 8'h00);
		queue_item(CMD_DATA, 8'hAA);
		queue_item(CMD_DATA, 8'h55);

		// total raised mid-stream: block runs out and a new header follows
		set_total(32'd2);
		queue_item(CMD_START, 8'h00);
		queue_item(CMD_DATA, 8'h12);
		set_total(32'd5);
		queue_item(CMD_DATA, 8'h34);
		queue_bytes(3);

		// total dropped below the bytes already taken
		set_total(32'd10);
		queue_item(CMD_START, 8'h00);
		queue_bytes(3);
		set_total(32'd1);
		queue_item(CMD_DATA, 8'h7E);

		// exactly one full block, final
		set_total(32'd65535);
		queue_item(CMD_START, 8'h00);

		random_traffic(120);

		// phase 2: the other way round
		settle();
		send_idle_pct = 60;
		recv_idle_pct = 37;
		random_traffic(245);

		// phase 3: no idling on either side
		settle();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_traffic(370);

		settle();
		repeat (20) @(posedge clk);

		$display("%0d input transactions, %0d stream bytes checked", items_sent,
			results_checked);
		$display("%0d streams closed, %0d overruns, %0d errors", streams_closed,
			overruns_seen, error_count);
		if (error_count == 0 && zlib_bytes_due.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// watchdog
	initial begin
		#(20_000_000);
		$display("*** FAILED ***");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/core/zsbf_pkg.sv
rtl/core/zsbf_core.sv
rtl/core/zsbf_serializer.sv
rtl/core/zlib_stored_block_framer.sv
rtl/core/zsbf_checker.sv
bench/zlib_stored_block_framer_tb.sv
